[rtl/lobm_pkg.sv]
// lobm_pkg: shared types and codes for the limit order book matcher
// status codes, operation and side codes, controller states, datapath commands and flags
// no dependencies
package lobm_pkg;

   localparam logic OPER_SUBMIT = 1'b0;
   localparam logic OPER_CANCEL = 1'b1;
   localparam logic SIDE_BID    = 1'b0;
   localparam logic SIDE_ASK    = 1'b1;

   typedef enum logic [1:0] {
      ST_DONE      = 2'd0,
      ST_ZERO      = 2'd1,
      ST_NOT_FOUND = 2'd2,
      ST_DROPPED   = 2'd3
   } status_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_DISPATCH,
      S_MATCH,
      S_MATCH_USE,
      S_REST_SRCH,
      S_REST_CHK,
      S_C_RD,
      S_C_CHK,
      S_C_SHIFT,
      S_C_SHIFT_WR,
      S_DONE
   } state_type;

   typedef enum logic [4:0] {
      OP_NONE,
      OP_LOAD,
      OP_ZERO,
      OP_MATCH_RD,
      OP_MATCH_USE,
      OP_RSTART,
      OP_LV_INC,
      OP_INSERT,
      OP_APPEND,
      OP_FULL,
      OP_CSIDE,
      OP_CNEXT_LV,
      OP_CRD,
      OP_CPOS_INC,
      OP_SHIFT_RD,
      OP_SHIFT_WR,
      OP_CREMOVE,
      OP_NOTFOUND,
      OP_OUT
   } dp_op_type;

   typedef struct packed {
      logic is_cancel;
      logic rem_zero;
      logic opp_empty;
      logic opp_cross;
      logic srch_stop;
      logic srch_hit;
      logic side_full;
      logic level_full;
      logic cur_in;
      logic sd_ask;
      logic pos_end;
      logic pos_last;
      logic id_match;
      logic out_free;
   } dp_flags_type;

endpackage

[rtl/lobm_if.sv]
// lobm_if: valid/ready channel interfaces for requests and responses
// widths follow the book parameters; no dependencies
interface lobm_req_if #(
   parameter int ID_BITS    = 32,
   parameter int PRICE_BITS = 32,
   parameter int QTY_BITS   = 32
) ();
   logic                  valid;
   logic                  ready;
   logic                  operation;
   logic [ID_BITS-1:0]    order_ref;
   logic                  side;
   logic [PRICE_BITS-1:0] price;
   logic [QTY_BITS-1:0]   quantity;

   modport source (output valid, operation, order_ref, side, price, quantity, input ready);
   modport sink   (input valid, operation, order_ref, side, price, quantity, output ready);
endinterface

interface lobm_rsp_if #(
   parameter int PRICE_BITS = 32,
   parameter int QTY_BITS   = 32
) ();
   logic                  valid;
   logic                  ready;
   logic [1:0]            status;
   logic [QTY_BITS-1:0]   executed_quantity;
   logic [QTY_BITS-1:0]   rested_quantity;
   logic                  best_bid_valid;
   logic [PRICE_BITS-1:0] best_bid;
   logic                  best_ask_valid;
   logic [PRICE_BITS-1:0] best_ask;

   modport source (output valid, status, executed_quantity, rested_quantity, best_bid_valid,
                   best_bid, best_ask_valid, best_ask, input ready);
   modport sink   (input valid, status, executed_quantity, rested_quantity, best_bid_valid,
                   best_bid, best_ask_valid, best_ask, output ready);
endinterface

[rtl/lobm_ctrl.sv]
// lobm_ctrl: sequencer for submit matching, resting and cancel search
// depends on lobm_pkg
module lobm_ctrl import lobm_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  dp_flags_type flags,
   output dp_op_type    op
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) state_in = S_DISPATCH;
         end
         S_DISPATCH: begin
            if (flags.is_cancel) state_in = S_C_RD;
            else if (flags.rem_zero) state_in = S_DONE;
            else state_in = S_MATCH;
         end
         S_MATCH: begin
            if (flags.rem_zero || flags.opp_empty || !flags.opp_cross) state_in = S_REST_SRCH;
            else state_in = S_MATCH_USE;
         end
         S_MATCH_USE: state_in = S_MATCH;
         S_REST_SRCH: begin
            if (flags.rem_zero) state_in = S_DONE;
            else if (flags.srch_stop) begin
               if (flags.srch_hit) state_in = S_REST_CHK;
               else if (flags.side_full) state_in = S_DONE;
               else state_in = S_REST_CHK;
            end
         end
         S_REST_CHK: state_in = S_DONE;
         S_C_RD: begin
            if (!flags.cur_in) begin
               if (flags.sd_ask) state_in = S_DONE;
            end else if (!flags.pos_end) begin
               state_in = S_C_CHK;
            end
         end
         S_C_CHK: begin
            if (flags.id_match) state_in = S_C_SHIFT;
            else state_in = S_C_RD;
         end
         S_C_SHIFT: begin
            if (flags.pos_last) state_in = S_DONE;
            else state_in = S_C_SHIFT_WR;
         end
         S_C_SHIFT_WR: state_in = S_C_SHIFT;
         S_DONE: begin
            if (flags.out_free) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      op        = OP_NONE;
      req_ready = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_ready = !reset;
            if (req_valid && !reset) op = OP_LOAD;
         end
         S_DISPATCH: begin
            if (!flags.is_cancel && flags.rem_zero) op = OP_ZERO;
         end
         S_MATCH: begin
            if (flags.rem_zero || flags.opp_empty || !flags.opp_cross) op = OP_RSTART;
            else op = OP_MATCH_RD;
         end
         S_MATCH_USE: op = OP_MATCH_USE;
         S_REST_SRCH: begin
            if (!flags.rem_zero) begin
               if (!flags.srch_stop) op = OP_LV_INC;
               else if (!flags.srch_hit) op = flags.side_full ? OP_FULL : OP_INSERT;
            end
         end
         S_REST_CHK: op = flags.level_full ? OP_FULL : OP_APPEND;
         S_C_RD: begin
            if (!flags.cur_in) op = flags.sd_ask ? OP_NOTFOUND : OP_CSIDE;
            else if (flags.pos_end) op = OP_CNEXT_LV;
            else op = OP_CRD;
         end
         S_C_CHK: begin
            if (!flags.id_match) op = OP_CPOS_INC;
         end
         S_C_SHIFT: op = flags.pos_last ? OP_CREMOVE : OP_SHIFT_RD;
         S_C_SHIFT_WR: op = OP_SHIFT_WR;
         S_DONE: begin
            if (flags.out_free) op = OP_OUT;
         end
         default: op = OP_NONE;
      endcase
   end

endmodule

[rtl/lobm_dpath.sv]
// lobm_dpath: level tables, order slot memory, working registers, response register
// depends on lobm_pkg; commanded by lobm_ctrl
module lobm_dpath import lobm_pkg::*; #(
   parameter int LEVELS           = 16,
   parameter int ORDERS_PER_LEVEL = 16,
   parameter int PRICE_BITS       = 32,
   parameter int QTY_BITS         = 32,
   parameter int ID_BITS          = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  dp_op_type             op,
   output dp_flags_type          flags,
   input  logic                  in_operation,
   input  logic [ID_BITS-1:0]    in_order_ref,
   input  logic                  in_side,
   input  logic [PRICE_BITS-1:0] in_price,
   input  logic [QTY_BITS-1:0]   in_quantity,
   input  logic                  rsp_ready,
   output logic                  rsp_valid,
   output logic [1:0]            rsp_status,
   output logic [QTY_BITS-1:0]   rsp_executed_quantity,
   output logic [QTY_BITS-1:0]   rsp_rested_quantity,
   output logic                  rsp_best_bid_valid,
   output logic [PRICE_BITS-1:0] rsp_best_bid,
   output logic                  rsp_best_ask_valid,
   output logic [PRICE_BITS-1:0] rsp_best_ask
);

   localparam int LW    = $clog2(LEVELS);
   localparam int CW    = $clog2(LEVELS + 1);
   localparam int PW    = (ORDERS_PER_LEVEL > 1) ? $clog2(ORDERS_PER_LEVEL) : 1;
   localparam int FW    = $clog2(ORDERS_PER_LEVEL + 1);
   localparam int SW    = $clog2(2 * ORDERS_PER_LEVEL + 1);
   localparam int SLOTS = LEVELS * ORDERS_PER_LEVEL;
   localparam int SAW   = $clog2(SLOTS);
   localparam int AW    = SAW + 1;
   localparam int DW    = ID_BITS + QTY_BITS;

   // circular position inside a level row
   function automatic logic [PW-1:0] wrap(input logic [PW-1:0] head, input logic [FW-1:0] pos);
      logic [SW-1:0] sum;
      sum = SW'(head) + SW'(pos);
      if (sum >= SW'(ORDERS_PER_LEVEL)) sum = sum - SW'(ORDERS_PER_LEVEL);
      return sum[PW-1:0];
   endfunction

   function automatic logic [AW-1:0] slot_addr(input logic sd, input logic [LW-1:0] row,
                                               input logic [PW-1:0] phys);
      logic [SAW-1:0] base;
      base = SAW'(row) * SAW'(ORDERS_PER_LEVEL) + SAW'(phys);
      return {sd, base};
   endfunction

   // level tables, one row of each per side
   logic [PRICE_BITS-1:0] price_ff [2][LEVELS];
   logic [PRICE_BITS-1:0] price_in [2][LEVELS];
   logic [FW-1:0]         fill_ff  [2][LEVELS];
   logic [FW-1:0]         fill_in  [2][LEVELS];
   logic [LW-1:0]         row_ff   [2][LEVELS];
   logic [LW-1:0]         row_in   [2][LEVELS];
   logic [PW-1:0]         head_ff  [2][LEVELS];
   logic [PW-1:0]         head_in  [2][LEVELS];
   logic [CW-1:0]         count_ff [2];
   logic [CW-1:0]         count_in [2];

   // order slots, side bit on top of the row/slot address
   logic [DW-1:0] mem [2**AW];
   logic [DW-1:0] rdata_ff;
   logic          mem_we, mem_re;
   logic [AW-1:0] mem_waddr, mem_raddr;
   logic [DW-1:0] mem_wdata;

   // working registers
   logic                  is_cancel_ff, is_cancel_in;
   logic [ID_BITS-1:0]    id_ff, id_in;
   logic                  side_ff, side_in;
   logic [PRICE_BITS-1:0] lim_ff, lim_in;
   logic [QTY_BITS-1:0]   rem_ff, rem_in;
   logic [QTY_BITS-1:0]   exec_ff, exec_in;
   logic [QTY_BITS-1:0]   rested_ff, rested_in;
   status_type            status_ff, status_in;
   logic                  sd_ff, sd_in;
   logic [CW-1:0]         lv_ff, lv_in;
   logic [FW-1:0]         pos_ff, pos_in;

   // response register
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [1:0]            o_status_ff;
   logic [QTY_BITS-1:0]   o_exec_ff, o_rested_ff;
   logic                  o_bbv_ff, o_bav_ff;
   logic [PRICE_BITS-1:0] o_bb_ff, o_ba_ff;

   logic                  opp;
   logic [LW-1:0]         cur_idx;
   logic [PRICE_BITS-1:0] cur_price, best_price;
   logic [FW-1:0]         cur_fill, best_fill;
   logic [LW-1:0]         cur_row, best_row;
   logic [PW-1:0]         cur_head, best_head;
   logic                  cur_in;
   logic [QTY_BITS-1:0]   rd_qty;
   logic [ID_BITS-1:0]    rd_id;
   logic                  head_gt;
   logic [AW-1:0]         match_addr;
   logic                  ahead;
   logic                  do_drop;
   logic                  drop_sd;
   logic [LW-1:0]         drop_k;
   logic [LW-1:0]         drop_row;

   assign opp        = ~side_ff;
   assign cur_idx    = lv_ff[LW-1:0];
   assign cur_price  = price_ff[sd_ff][cur_idx];
   assign cur_fill   = fill_ff[sd_ff][cur_idx];
   assign cur_row    = row_ff[sd_ff][cur_idx];
   assign cur_head   = head_ff[sd_ff][cur_idx];
   assign cur_in     = lv_ff < count_ff[sd_ff];
   assign best_price = price_ff[opp][0];
   assign best_fill  = fill_ff[opp][0];
   assign best_row   = row_ff[opp][0];
   assign best_head  = head_ff[opp][0];
   assign rd_qty     = rdata_ff[QTY_BITS-1:0];
   assign rd_id      = rdata_ff[DW-1:QTY_BITS];
   assign head_gt    = rd_qty > rem_ff;
   assign match_addr = slot_addr(opp, best_row, best_head);
   assign ahead      = (sd_ff == SIDE_BID) ? (lim_ff > cur_price) : (lim_ff < cur_price);

   always_comb begin
      flags.is_cancel  = is_cancel_ff;
      flags.rem_zero   = rem_ff == '0;
      flags.opp_empty  = count_ff[opp] == '0;
      flags.opp_cross  = (side_ff == SIDE_BID) ? (lim_ff >= best_price) : (lim_ff <= best_price);
      flags.srch_stop  = !cur_in || (cur_price == lim_ff) || ahead;
      flags.srch_hit   = cur_in && (cur_price == lim_ff);
      flags.side_full  = count_ff[sd_ff] >= CW'(LEVELS);
      flags.level_full = cur_fill >= FW'(ORDERS_PER_LEVEL);
      flags.cur_in     = cur_in;
      flags.sd_ask     = sd_ff == SIDE_ASK;
      flags.pos_end    = pos_ff >= cur_fill;
      flags.pos_last   = ((FW+1)'(pos_ff) + (FW+1)'(1)) >= (FW+1)'(cur_fill);
      flags.id_match   = rd_id == id_ff;
      flags.out_free   = !rsp_valid_ff || rsp_ready;
   end

   // slot memory port
   always_comb begin
      mem_we    = 1'b0;
      mem_re    = 1'b0;
      mem_waddr = match_addr;
      mem_raddr = match_addr;
      mem_wdata = rdata_ff;
      case (op)
         OP_MATCH_RD: mem_re = 1'b1;
         OP_MATCH_USE: begin
            mem_we    = head_gt;
            mem_wdata = {rd_id, rd_qty - rem_ff};
         end
         OP_CRD: begin
            mem_re    = 1'b1;
            mem_raddr = slot_addr(sd_ff, cur_row, wrap(cur_head, pos_ff));
         end
         OP_SHIFT_RD: begin
            mem_re    = 1'b1;
            mem_raddr = slot_addr(sd_ff, cur_row, wrap(cur_head, pos_ff + FW'(1)));
         end
         OP_SHIFT_WR: begin
            mem_we    = 1'b1;
            mem_waddr = slot_addr(sd_ff, cur_row, wrap(cur_head, pos_ff));
         end
         OP_APPEND: begin
            mem_we    = 1'b1;
            mem_waddr = slot_addr(sd_ff, cur_row, wrap(cur_head, cur_fill));
            mem_wdata = {id_ff, rem_ff};
         end
         default: mem_we = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) mem[mem_waddr] <= mem_wdata;
      if (mem_re) rdata_ff <= mem[mem_raddr];
   end

   // level table updates: pop, remove, append, drop (shift up, freed row parked at the end), insert
   always_comb begin
      price_in = price_ff;
      fill_in  = fill_ff;
      row_in   = row_ff;
      head_in  = head_ff;
      count_in = count_ff;
      do_drop  = 1'b0;
      drop_sd  = opp;
      drop_k   = '0;
      case (op)
         OP_MATCH_USE: begin
            if (!head_gt) begin
               if (best_fill == FW'(1)) begin
                  do_drop = 1'b1;
               end else begin
                  fill_in[opp][0] = best_fill - FW'(1);
                  head_in[opp][0] = wrap(best_head, FW'(1));
               end
            end
         end
         OP_CREMOVE: begin
            if (cur_fill == FW'(1)) begin
               do_drop = 1'b1;
               drop_sd = sd_ff;
               drop_k  = cur_idx;
            end else begin
               fill_in[sd_ff][cur_idx] = cur_fill - FW'(1);
            end
         end
         OP_INSERT: begin
            for (int j = 1; j < LEVELS; j++) begin
               if (LW'(j) > cur_idx) begin
                  price_in[sd_ff][j] = price_ff[sd_ff][j-1];
                  fill_in[sd_ff][j]  = fill_ff[sd_ff][j-1];
                  row_in[sd_ff][j]   = row_ff[sd_ff][j-1];
                  head_in[sd_ff][j]  = head_ff[sd_ff][j-1];
               end
            end
            price_in[sd_ff][cur_idx] = lim_ff;
            fill_in[sd_ff][cur_idx]  = '0;
            row_in[sd_ff][cur_idx]   = row_ff[sd_ff][LEVELS-1];
            head_in[sd_ff][cur_idx]  = '0;
            count_in[sd_ff]          = count_ff[sd_ff] + CW'(1);
         end
         OP_APPEND: fill_in[sd_ff][cur_idx] = cur_fill + FW'(1);
         default: do_drop = 1'b0;
      endcase
      drop_row = row_ff[drop_sd][drop_k];
      if (do_drop) begin
         for (int j = 0; j < LEVELS - 1; j++) begin
            if (LW'(j) >= drop_k) begin
               price_in[drop_sd][j] = price_ff[drop_sd][j+1];
               fill_in[drop_sd][j]  = fill_ff[drop_sd][j+1];
               row_in[drop_sd][j]   = row_ff[drop_sd][j+1];
               head_in[drop_sd][j]  = head_ff[drop_sd][j+1];
            end
         end
         fill_in[drop_sd][LEVELS-1] = '0;
         row_in[drop_sd][LEVELS-1]  = drop_row;
         count_in[drop_sd]          = count_ff[drop_sd] - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < 2; s++) begin
            count_ff[s] <= '0;
            for (int j = 0; j < LEVELS; j++) begin
               fill_ff[s][j] <= '0;
               row_ff[s][j]  <= LW'(j);
            end
         end
      end else begin
         count_ff <= count_in;
         fill_ff  <= fill_in;
         row_ff   <= row_in;
      end
   end

   always_ff @(posedge clock) begin
      price_ff <= price_in;
      head_ff  <= head_in;
   end

   // working registers
   always_comb begin
      is_cancel_in = is_cancel_ff;
      id_in        = id_ff;
      side_in      = side_ff;
      lim_in       = lim_ff;
      rem_in       = rem_ff;
      exec_in      = exec_ff;
      rested_in    = rested_ff;
      status_in    = status_ff;
      sd_in        = sd_ff;
      lv_in        = lv_ff;
      pos_in       = pos_ff;
      case (op)
         OP_LOAD: begin
            is_cancel_in = in_operation == OPER_CANCEL;
            id_in        = in_order_ref;
            side_in      = in_side;
            lim_in       = in_price;
            rem_in       = in_quantity;
            exec_in      = '0;
            rested_in    = '0;
            status_in    = ST_DONE;
            sd_in        = SIDE_BID;
            lv_in        = '0;
            pos_in       = '0;
         end
         OP_ZERO: status_in = ST_ZERO;
         OP_MATCH_USE: begin
            if (head_gt) begin
               exec_in = exec_ff + rem_ff;
               rem_in  = '0;
            end else begin
               exec_in = exec_ff + rd_qty;
               rem_in  = rem_ff - rd_qty;
            end
         end
         OP_RSTART: begin
            sd_in = side_ff;
            lv_in = '0;
         end
         OP_LV_INC: lv_in = lv_ff + CW'(1);
         OP_FULL: status_in = ST_DROPPED;
         OP_APPEND: rested_in = rem_ff;
         OP_CSIDE: begin
            sd_in  = SIDE_ASK;
            lv_in  = '0;
            pos_in = '0;
         end
         OP_CNEXT_LV: begin
            lv_in  = lv_ff + CW'(1);
            pos_in = '0;
         end
         OP_CPOS_INC: pos_in = pos_ff + FW'(1);
         OP_SHIFT_WR: pos_in = pos_ff + FW'(1);
         OP_NOTFOUND: status_in = ST_NOT_FOUND;
         default: pos_in = pos_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      is_cancel_ff <= is_cancel_in;
      id_ff        <= id_in;
      side_ff      <= side_in;
      lim_ff       <= lim_in;
      rem_ff       <= rem_in;
      exec_ff      <= exec_in;
      rested_ff    <= rested_in;
      status_ff    <= status_in;
      sd_ff        <= sd_in;
      lv_ff        <= lv_in;
      pos_ff       <= pos_in;
   end

   // response register
   always_comb begin
      if (op == OP_OUT) rsp_valid_in = 1'b1;
      else if (rsp_ready) rsp_valid_in = 1'b0;
      else rsp_valid_in = rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (op == OP_OUT) begin
         o_status_ff <= status_ff;
         o_exec_ff   <= exec_ff;
         o_rested_ff <= rested_ff;
         o_bbv_ff    <= count_ff[SIDE_BID] != '0;
         o_bb_ff     <= (count_ff[SIDE_BID] != '0) ? price_ff[SIDE_BID][0] : '0;
         o_bav_ff    <= count_ff[SIDE_ASK] != '0;
         o_ba_ff     <= (count_ff[SIDE_ASK] != '0) ? price_ff[SIDE_ASK][0] : '0;
      end
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_status            = o_status_ff;
   assign rsp_executed_quantity = o_exec_ff;
   assign rsp_rested_quantity   = o_rested_ff;
   assign rsp_best_bid_valid    = o_bbv_ff;
   assign rsp_best_bid          = o_bb_ff;
   assign rsp_best_ask_valid    = o_bav_ff;
   assign rsp_best_ask          = o_ba_ff;

endmodule

[rtl/limit_order_book_matcher.sv]
// limit_order_book_matcher: top level of the price-time priority order book
// depends on lobm_pkg, lobm_if, lobm_ctrl, lobm_dpath
//
// usage
//   req_chan carries one request per transaction: submit (side, price, quantity, id)
//   or cancel by id. rsp_chan returns exactly one status transaction per request with
//   executed and rested quantity and the best bid and ask after the request.
//   requests are handled one at a time; req_chan.ready is high only while idle.
// steps
//   submit: a read and an update of each resting order it fills against, a search step
//   per own-side level walked to find its price, then a check and an append to rest.
//   cancel: a read and a check per order slot examined (bids best to worst, then asks)
//   plus a read and a write per order shifted behind the removed one. the order slot
//   memory port (one read or write a cycle) sets the pace of these steps.
// reset
//   synchronous; empties both sides at once, no clearing pass; req_chan.ready is
//   held low while reset is high.
// stall
//   a response waits in the output register while rsp_chan.ready is low; the next
//   request is taken and worked on, and holds at its end until the register frees.
module limit_order_book_matcher import lobm_pkg::*; #(
   parameter int LEVELS           = 16,
   parameter int ORDERS_PER_LEVEL = 16,
   parameter int PRICE_BITS       = 32,
   parameter int QTY_BITS         = 32,
   parameter int ID_BITS          = 32
) (
   input  logic       clock,
   input  logic       reset,
   lobm_req_if.sink   req_chan,
   lobm_rsp_if.source rsp_chan
);

   dp_flags_type flags;
   dp_op_type    op;

   // sequencer: one command per cycle into the datapath
   lobm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .flags     (flags),
      .op        (op)
   );

   // book storage, matching arithmetic and response register
   lobm_dpath #(
      .LEVELS           (LEVELS),
      .ORDERS_PER_LEVEL (ORDERS_PER_LEVEL),
      .PRICE_BITS       (PRICE_BITS),
      .QTY_BITS         (QTY_BITS),
      .ID_BITS          (ID_BITS)
   ) u_dpath (
      .clock                 (clock),
      .reset                 (reset),
      .op                    (op),
      .flags                 (flags),
      .in_operation          (req_chan.operation),
      .in_order_ref          (req_chan.order_ref),
      .in_side               (req_chan.side),
      .in_price              (req_chan.price),
      .in_quantity           (req_chan.quantity),
      .rsp_ready             (rsp_chan.ready),
      .rsp_valid             (rsp_chan.valid),
      .rsp_status            (rsp_chan.status),
      .rsp_executed_quantity (rsp_chan.executed_quantity),
      .rsp_rested_quantity   (rsp_chan.rested_quantity),
      .rsp_best_bid_valid    (rsp_chan.best_bid_valid),
      .rsp_best_bid          (rsp_chan.best_bid),
      .rsp_best_ask_valid    (rsp_chan.best_ask_valid),
      .rsp_best_ask          (rsp_chan.best_ask)
   );

endmodule
